FILE: src/rde_pkg.sv
// Shared constants and codes for the reversible deque engine.
package rde_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 16;

  localparam int REQ_W = 2;
  localparam int VAL_W = 16;
  localparam int STS_W = 2;

  localparam logic [REQ_W-1:0] REQ_PUSH    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REVERSE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DRAIN   = 2'd3;

  localparam logic [STS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STATUS_ERROR    = 2'd1;
  localparam logic [STS_W-1:0] STATUS_OVERFLOW = 2'd2;

endpackage

FILE: src/rde_ifs.sv
// Request and result channel interfaces of the reversible deque engine.
interface rde_req_if;
  logic                       valid;
  logic                       ready;
  logic [rde_pkg::REQ_W-1:0] req_type;
  logic [rde_pkg::VAL_W-1:0] value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface rde_res_if;
  logic                       valid;
  logic                       ready;
  logic [rde_pkg::VAL_W-1:0] value_res;
  logic [rde_pkg::STS_W-1:0] status;
  logic                       empty_res;
  logic                       last;

  modport source (output valid, output value_res, output status, output empty_res,
                  output last, input ready);
  modport sink   (input valid, input value_res, input status, input empty_res,
                  input last, output ready);
endinterface

FILE: src/rde_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/reversible_deque_engine.sv
// Push, reverse and delete complete in the accepting cycle and give no word.
// Drain of an empty or faulted store: one status word, valid the cycle after acceptance.
// Drain of N elements: a RAM read, then the output register; then one word per cycle
// while res_ch is ready (single registered RAM read port); next request after last.
// Reset (rst, synchronous) clears head, count, reverse/error/overflow flags and the
// output valid; element RAM contents are left as they are and never read unwritten.
module reversible_deque_engine #(
  parameter int DEPTH       = rde_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  rde_req_if.sink       req_ch,
  rde_res_if.source     res_ch
);

  // index, count and sum widths all follow DEPTH
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int VW = rde_pkg::VAL_W;
  localparam int TW = rde_pkg::STS_W;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  // control state
  logic          state;
  logic [AW-1:0] head;
  logic [CW-1:0] count;
  logic          rev;
  logic          err;
  logic          ovf;
  logic [CW-1:0] idx;        // next element of a drain run to read
  logic [TW-1:0] d_status;   // status carried by every word of the run
  logic          rd_pend;    // RAM read data holds an element not yet loaded
  logic          pend_last;

  // output register
  logic          ovalid;
  logic [VW-1:0] o_value;
  logic [TW-1:0] o_status;
  logic          o_empty;
  logic          o_last;

  logic                   req_acc;
  logic                   out_free;
  logic                   load_now;
  logic                   issue;
  logic                   is_last_issue;
  logic                   push_ok;
  logic [CW-1:0]          off;
  logic [SW-1:0]          rd_sum;
  logic [SW-1:0]          wr_sum;
  logic [SW-1:0]          hd_sum;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          wr_addr;
  logic [AW-1:0]          head_inc;
  logic [VALUE_WIDTH-1:0] wdata;
  logic [VALUE_WIDTH-1:0] rdata;

  assign out_free = !ovalid || res_ch.ready;
  // requests wait for a free output slot and an empty read pipe
  assign req_ch.ready = (state == ST_IDLE) && !rd_pend && out_free;
  assign req_acc  = req_ch.valid && req_ch.ready;
  assign load_now = rd_pend && out_free;
  assign issue    = (state == ST_DRAIN) && (!rd_pend || load_now);
  assign is_last_issue = (SW'(idx) + SW'(1)) == SW'(count);

  // logical position -> physical offset from head
  assign off = rev ? (count - CW'(1) - idx) : idx;

  // ring wrap: sums stay below 2*DEPTH, so one compare and subtract
  always_comb begin
    rd_sum = SW'(head) + SW'(off);
    if (rd_sum >= SW'(DEPTH)) begin
      rd_sum = rd_sum - SW'(DEPTH);
    end
    wr_sum = SW'(head) + SW'(count);
    if (wr_sum >= SW'(DEPTH)) begin
      wr_sum = wr_sum - SW'(DEPTH);
    end
    hd_sum = SW'(head) + SW'(1);
    if (hd_sum >= SW'(DEPTH)) begin
      hd_sum = hd_sum - SW'(DEPTH);
    end
  end

  assign rd_addr  = rd_sum[AW-1:0];
  assign wr_addr  = wr_sum[AW-1:0];
  assign head_inc = hd_sum[AW-1:0];

  assign push_ok = req_acc && (req_ch.req_type == rde_pkg::REQ_PUSH) && !err &&
                   (SW'(count) < SW'(DEPTH));
  assign wdata   = VALUE_WIDTH'(req_ch.value);

  rde_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (push_ok),
    .waddr (wr_addr),
    .wdata (wdata),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      rev       <= 1'b0;
      err       <= 1'b0;
      ovf       <= 1'b0;
      idx       <= '0;
      d_status  <= rde_pkg::STATUS_OK;
      rd_pend   <= 1'b0;
      pend_last <= 1'b0;
      ovalid    <= 1'b0;
    end else begin
      if (ovalid && res_ch.ready) begin
        ovalid <= 1'b0;
      end
      if (load_now) begin
        ovalid <= 1'b1;
      end

      if (issue) begin
        rd_pend   <= 1'b1;
        pend_last <= is_last_issue;
      end else if (load_now) begin
        rd_pend <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (req_acc) begin
            unique case (req_ch.req_type)
              rde_pkg::REQ_PUSH: begin
                if (!err) begin
                  if (push_ok) begin
                    count <= count + CW'(1);
                  end else begin
                    ovf <= 1'b1;   // full: word dropped
                  end
                end
              end
              rde_pkg::REQ_REVERSE: begin
                if (!err) begin
                  rev <= !rev;
                end
              end
              rde_pkg::REQ_DELETE: begin
                if (!err) begin
                  if (count == '0) begin
                    err <= 1'b1;
                  end else begin
                    // reversed: logical front is the physical back, head stays
                    if (!rev) begin
                      head <= head_inc;
                    end
                    count <= count - CW'(1);
                  end
                end
              end
              rde_pkg::REQ_DRAIN: begin
                if (err || (count == '0)) begin
                  // single status word, then back to reset values
                  ovalid <= 1'b1;
                  head   <= '0;
                  count  <= '0;
                  rev    <= 1'b0;
                  err    <= 1'b0;
                  ovf    <= 1'b0;
                end else begin
                  state    <= ST_DRAIN;
                  idx      <= '0;
                  d_status <= ovf ? rde_pkg::STATUS_OVERFLOW : rde_pkg::STATUS_OK;
                end
              end
              default: ;
            endcase
          end
        end
        ST_DRAIN: begin
          if (issue) begin
            idx <= idx + CW'(1);
            if (is_last_issue) begin
              state <= ST_IDLE;
              head  <= '0;
              count <= '0;
              rev   <= 1'b0;
              err   <= 1'b0;
              ovf   <= 1'b0;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_now) begin
      o_value  <= VW'(rdata);
      o_status <= d_status;
      o_empty  <= 1'b0;
      o_last   <= pend_last;
    end else if (req_acc && (req_ch.req_type == rde_pkg::REQ_DRAIN)) begin
      o_value  <= '0;
      o_empty  <= 1'b1;
      o_last   <= 1'b1;
      if (err) begin
        o_status <= rde_pkg::STATUS_ERROR;
      end else if (ovf) begin
        o_status <= rde_pkg::STATUS_OVERFLOW;
      end else begin
        o_status <= rde_pkg::STATUS_OK;
      end
    end
  end

  assign res_ch.valid     = ovalid;
  assign res_ch.value_res = o_value;
  assign res_ch.status    = o_status;
  assign res_ch.empty_res = o_empty;
  assign res_ch.last      = o_last;

endmodule

FILE: src/rde_checker.sv
// Port-level checker for the reversible deque engine, bound to the top level.
module rde_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_ready,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic [rde_pkg::VAL_W-1:0] res_value,
  input logic [rde_pkg::STS_W-1:0] res_status,
  input logic                       res_empty,
  input logic                       res_last
);

  // a stalled result word stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result word dropped while stalled");

  // no request taken while a result word is stuck
  a_no_req_on_stall: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !req_ready)
    else $error("request accepted with result word stalled");

  // status-only word carries no element and ends the run
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_empty |-> res_last && (res_value == '0))
    else $error("empty word malformed");

  // delete-on-empty error only shows on a status-only word
  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_status == rde_pkg::STATUS_ERROR) |-> res_empty)
    else $error("error status on element word");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (
  .clk        (clk),
  .rst        (rst),
  .req_ready  (req_ch.ready),
  .res_valid  (res_ch.valid),
  .res_ready  (res_ch.ready),
  .res_value  (res_ch.value_res),
  .res_status (res_ch.status),
  .res_empty  (res_ch.empty_res),
  .res_last   (res_ch.last)
);
